// ===== src/dwhc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the dictionary word hit counter
// no dependencies; imported by every module of the block

package dwhc_pkg;

    // dictionary geometry (word bytes must be a power of two: slot and byte form the address)
    localparam int WORD_SLOTS  = 65536;
    localparam int WORD_BYTES  = 64;
    localparam int SLOT_W      = $clog2(WORD_SLOTS);
    localparam int COUNT_W     = $clog2(WORD_SLOTS + 1);
    localparam int POS_W       = $clog2(WORD_BYTES);
    localparam int LOADPOS_W   = $clog2(WORD_BYTES + 1);
    localparam int DICT_ADDR_W = SLOT_W + POS_W;
    localparam int DICT_DEPTH  = WORD_SLOTS * WORD_BYTES;

    // result and text constants
    localparam int          HIT_W     = 16;
    localparam logic [7:0]  SEPARATOR = 8'd32;
    localparam logic [7:0]  NUL_CHAR  = 8'd0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input item commands
    localparam logic CMD_DICT = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    // operation kinds handed to the back end
    typedef enum logic [1:0] {
        OP_DICT,
        OP_APPEND,
        OP_FINISH,
        OP_NONE
    } t_op_kind;

    // one queued operation; last ends a dictionary word or the message
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] ch;
        logic       last;
    } t_op;

endpackage

// ===== src/dwhc_front.sv =====
`timescale 1ns / 1ps
// front end: takes input items, classifies them into queue operations
// depends on dwhc_pkg; feeds dwhc_queue

module dwhc_front import dwhc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_cmd,
    input  logic [7:0] i_char_code,
    input  logic       i_last,
    output logic       o_push,
    output t_op        o_op
);

    logic r_text_ended;
    logic n_text_ended;

    // classify the item
    always_comb begin
        o_op.ch   = i_char_code;
        o_op.last = i_last;
        if (i_cmd == CMD_DICT) begin
            o_op.kind = OP_DICT;
        end else if (r_text_ended) begin
            o_op.kind = OP_NONE;
        end else if (i_char_code == NUL_CHAR || i_char_code == SEPARATOR) begin
            o_op.kind = OP_FINISH;
        end else begin
            o_op.kind = OP_APPEND;
        end
        // ignored text bytes only matter when they end the message
        o_push = i_accept && (o_op.kind != OP_NONE || i_last);
    end

    // track a zero byte that ends the text early
    always_comb begin
        n_text_ended = r_text_ended;
        if (i_accept && i_cmd == CMD_TEXT) begin
            if (i_last) begin
                n_text_ended = 1'b0;
            end else if (i_char_code == NUL_CHAR) begin
                n_text_ended = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_ended <= 1'b0;
        end else begin
            r_text_ended <= n_text_ended;
        end
    end

endmodule

// ===== src/dwhc_queue.sv =====
`timescale 1ns / 1ps
// short fifo of operations between the front and back ends
// depends on dwhc_pkg

module dwhc_queue import dwhc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_not_empty,
    output t_op  o_head
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== src/dwhc_back.sv =====
`timescale 1ns / 1ps
// back end: dictionary load, token buffer, binary search and hit count
// depends on dwhc_pkg; takes operations from dwhc_queue

module dwhc_back import dwhc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_op              i_head,
    output logic             o_pop,
    output logic             o_valid,
    output logic [HIT_W-1:0] o_hit_count,
    output logic             o_dict_overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TERM,
        S_FINISH,
        S_PROBE,
        S_READ,
        S_CMP,
        S_CLEAR
    } t_state;

    t_state               r_state,     n_state;
    logic [LOADPOS_W-1:0] r_load_pos,  n_load_pos;
    logic [COUNT_W-1:0]   r_loaded,    n_loaded;
    logic                 r_overflow,  n_overflow;
    logic [POS_W-1:0]     r_term_pos,  n_term_pos;
    logic [LOADPOS_W-1:0] r_tok_len,   n_tok_len;
    logic                 r_tok_over,  n_tok_over;
    logic [HIT_W-1:0]     r_total,     n_total;
    logic                 r_emit,      n_emit;
    logic                 r_hit,       n_hit;
    logic [COUNT_W-1:0]   r_low,       n_low;
    logic [COUNT_W-1:0]   r_hix,       n_hix;
    logic [SLOT_W-1:0]    r_mid,       n_mid;
    logic [POS_W-1:0]     r_idx,       n_idx;
    logic                 r_valid,     n_valid;
    logic [HIT_W-1:0]     r_hit_count, n_hit_count;
    logic                 r_ovf_out,   n_ovf_out;

    // memories and their ports
    logic [7:0]             r_dict_mem [DICT_DEPTH];
    logic [7:0]             r_tok_mem  [WORD_BYTES];
    logic [7:0]             r_dict_q;
    logic [7:0]             r_tok_q;
    logic                   dict_we;
    logic [DICT_ADDR_W-1:0] dict_addr;
    logic [7:0]             dict_wdata;
    logic                   tok_we;
    logic [POS_W-1:0]       tok_waddr;
    logic [POS_W-1:0]       tok_raddr;

    // search helpers
    logic [COUNT_W:0]  mid_sum;
    logic [7:0]        tok_byte;
    logic [HIT_W-1:0]  total_next;
    logic              word_fits;

    assign mid_sum    = {1'b0, r_low} + {1'b0, r_hix} - 1'b1;
    assign tok_byte   = ({1'b0, r_idx} < r_tok_len) ? r_tok_q : NUL_CHAR;
    assign total_next = (r_hit && r_total != '1) ? r_total + 1'b1 : r_total;
    assign word_fits  = (r_load_pos < LOADPOS_W'(WORD_BYTES - 1))
                        && (r_loaded < COUNT_W'(WORD_SLOTS));

    assign o_valid         = r_valid;
    assign o_hit_count     = r_hit_count;
    assign o_dict_overflow = r_ovf_out;

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_load_pos  = r_load_pos;
        n_loaded    = r_loaded;
        n_overflow  = r_overflow;
        n_term_pos  = r_term_pos;
        n_tok_len   = r_tok_len;
        n_tok_over  = r_tok_over;
        n_total     = r_total;
        n_emit      = r_emit;
        n_hit       = r_hit;
        n_low       = r_low;
        n_hix       = r_hix;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_valid     = 1'b0;
        n_hit_count = r_hit_count;
        n_ovf_out   = r_ovf_out;
        o_pop       = 1'b0;
        dict_we     = 1'b0;
        dict_addr   = {r_mid, r_idx};
        dict_wdata  = i_head.ch;
        tok_we      = 1'b0;
        tok_waddr   = r_tok_len[POS_W-1:0];
        tok_raddr   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_head.kind == OP_DICT) begin
                        // store a dictionary byte in the slot being filled
                        dict_addr = {r_loaded[SLOT_W-1:0], r_load_pos[POS_W-1:0]};
                        if (r_load_pos < LOADPOS_W'(WORD_BYTES - 1)) begin
                            dict_we    = (r_loaded < COUNT_W'(WORD_SLOTS));
                            n_load_pos = r_load_pos + 1'b1;
                        end else begin
                            n_load_pos = LOADPOS_W'(WORD_BYTES);
                        end
                        if (i_head.last) begin
                            if (word_fits) begin
                                n_term_pos = POS_W'(r_load_pos + 1'b1);
                                n_state    = S_TERM;
                            end else begin
                                n_overflow = 1'b1;
                            end
                            n_load_pos = '0;
                        end
                    end else begin
                        // text byte into the token buffer; a token end starts the search
                        if (i_head.kind == OP_APPEND) begin
                            if (r_tok_len < LOADPOS_W'(WORD_BYTES - 1)) begin
                                tok_we    = 1'b1;
                                n_tok_len = r_tok_len + 1'b1;
                            end else begin
                                n_tok_over = 1'b1;
                            end
                        end
                        if (i_head.kind != OP_APPEND || i_head.last) begin
                            n_emit  = i_head.last;
                            n_state = S_FINISH;
                        end
                    end
                end
            end

            S_TERM: begin
                // terminating zero commits the word
                dict_we    = 1'b1;
                dict_addr  = {r_loaded[SLOT_W-1:0], r_term_pos};
                dict_wdata = NUL_CHAR;
                n_loaded   = r_loaded + 1'b1;
                n_state    = S_IDLE;
            end

            S_FINISH: begin
                n_hit = 1'b0;
                if (r_tok_len == '0 || r_tok_over) begin
                    n_state = S_CLEAR;
                end else begin
                    n_low   = '0;
                    n_hix   = r_loaded;
                    n_state = S_PROBE;
                end
            end

            S_PROBE: begin
                // pick the middle slot of the open range
                if (r_low < r_hix) begin
                    n_mid   = mid_sum[SLOT_W:1];
                    n_idx   = '0;
                    n_state = S_READ;
                end else begin
                    n_state = S_CLEAR;
                end
            end

            S_READ: begin
                n_state = S_CMP;
            end

            S_CMP: begin
                // byte-serial compare of token and slot
                if (tok_byte != r_dict_q) begin
                    if (tok_byte < r_dict_q) begin
                        n_hix = COUNT_W'(r_mid);
                    end else begin
                        n_low = COUNT_W'(r_mid) + 1'b1;
                    end
                    n_state = S_PROBE;
                end else if (tok_byte == NUL_CHAR || r_idx == POS_W'(WORD_BYTES - 1)) begin
                    n_hit   = 1'b1;
                    n_state = S_CLEAR;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end

            S_CLEAR: begin
                // count the hit, drop the token, report at message end
                n_tok_len  = '0;
                n_tok_over = 1'b0;
                n_hit      = 1'b0;
                if (r_emit) begin
                    n_valid     = 1'b1;
                    n_hit_count = total_next;
                    n_ovf_out   = r_overflow;
                    n_total     = '0;
                    n_emit      = 1'b0;
                end else begin
                    n_total = total_next;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_pos <= '0;
            r_loaded   <= '0;
            r_overflow <= 1'b0;
            r_tok_len  <= '0;
            r_tok_over <= 1'b0;
            r_total    <= '0;
            r_emit     <= 1'b0;
            r_hit      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_loaded   <= n_loaded;
            r_overflow <= n_overflow;
            r_tok_len  <= n_tok_len;
            r_tok_over <= n_tok_over;
            r_total    <= n_total;
            r_emit     <= n_emit;
            r_hit      <= n_hit;
            r_valid    <= n_valid;
        end
        r_term_pos  <= n_term_pos;
        r_low       <= n_low;
        r_hix       <= n_hix;
        r_mid       <= n_mid;
        r_idx       <= n_idx;
        r_hit_count <= n_hit_count;
        r_ovf_out   <= n_ovf_out;
    end

    // dictionary store, one port
    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            r_dict_mem[dict_addr] <= dict_wdata;
        end
        r_dict_q <= r_dict_mem[dict_addr];
    end

    // token buffer, one write and one read port
    always_ff @(posedge i_clk) begin
        if (tok_we) begin
            r_tok_mem[tok_waddr] <= i_head.ch;
        end
        r_tok_q <= r_tok_mem[tok_raddr];
    end

endmodule

// ===== src/dictionary_word_hit_counter.sv =====
`timescale 1ns / 1ps
// top level of the dictionary word hit counter
// depends on dwhc_pkg, dwhc_front, dwhc_queue and dwhc_back

// Items are taken while busy is low; busy rises only when the four-entry
// operation queue is full. The back end handles one queued item at a time:
// a dictionary byte that ends a kept word also writes its terminating zero,
// and a token end passes the finish, probe, read, compare and clear states,
// with a read and a compare for each byte compared in each binary search
// probe, since the single-port dictionary memory is read one byte per probe
// step; with n words loaded a token needs up to about log2(n)+1 probes. The
// message-end item gives one result, registered out of the clear state, on
// o_valid for exactly one cycle; the receiver cannot stall it. The dictionary
// store needs no clearing after reset.

module dictionary_word_hit_counter import dwhc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cmd,
    input  logic [7:0]       i_char_code,
    input  logic             i_last,
    output logic             o_valid,
    output logic [HIT_W-1:0] o_hit_count,
    output logic             o_dict_overflow
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic not_empty;
    t_op  front_op;
    t_op  head_op;

    assign busy   = full;
    assign accept = start && !full;

    // classify incoming items
    dwhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_push      (push),
        .o_op        (front_op)
    );

    // decouple front and back
    dwhc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (front_op),
        .i_pop       (pop),
        .o_full      (full),
        .o_not_empty (not_empty),
        .o_head      (head_op)
    );

    // load, search and count
    dwhc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (not_empty),
        .i_head          (head_op),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_hit_count     (o_hit_count),
        .o_dict_overflow (o_dict_overflow)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for dictionary_word_hit_counter: directed, random, full dictionary
// depends on dwhc_pkg and the block's RTL; expected hits: built-in scoring model or directed table

module tb_top;
    import dwhc_pkg::*;

    localparam int STALL_LIMIT  = 40000;
    localparam int TAIL_CYCLES  = 3000;
    localparam int RANDOM_ITEMS = 650;
    localparam int MAX_REPORTS  = 40;
    // markers in table strings: '@' stands for a zero byte, '~' for byte 0xff
    localparam logic [7:0] ZERO_MARK = 8'h40;
    localparam logic [7:0] HIGH_MARK = 8'h7E;

    typedef logic [7:0] t_bytes[$];

    typedef struct packed {
        logic [HIT_W-1:0] hit_count;
        logic             dict_overflow;
    } t_tally;

    typedef struct {
        logic  cmd;
        string head;
        string rep;
        int    reps;
        logic  fin;
        bit    chk;
        int    hits;
        logic  ovf;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_cmd;
    logic [7:0]       i_char_code;
    logic             i_last;
    logic             o_valid;
    logic [HIT_W-1:0] o_hit_count;
    logic             o_dict_overflow;

    // scoring model state
    logic [7:0]       dict_bytes [int];
    int               word_total = 0;
    int               load_len = 0;
    logic [7:0]       tok_bytes [WORD_BYTES];
    int               tok_len = 0;
    bit               tok_over = 1'b0;
    bit               text_done = 1'b0;
    bit               ovf_seen = 1'b0;
    logic [HIT_W-1:0] hit_total = '0;

    t_tally expected_tallies[$];
    int     fail_count = 0;
    int     used_items = 0;
    int     idle_cycles = 0;
    int     idle_pct = 0;
    int     word_code = 0;
    int     fill_code = 0;

    // directed table: dictionary words, extremes and corner cases
    t_row dir_rows [21] = '{
        '{CMD_TEXT, "hello",        "",   0,     1'b1, 1'b1, 0,     1'b0},
        '{CMD_TEXT, " ",            "",   0,     1'b1, 1'b1, 0,     1'b0},
        '{CMD_TEXT, "@",            "",   0,     1'b1, 1'b1, 0,     1'b0},
        '{CMD_DICT, "A",            "",   0,     1'b1, 1'b0, 0,     1'b0},
        '{CMD_TEXT, "",             "A ", 65536, 1'b1, 1'b1, 65535, 1'b0},
        '{CMD_DICT, "B@C",          "",   0,     1'b1, 1'b0, 0,     1'b0},
        '{CMD_DICT, "C",            "x",  62,    1'b1, 1'b0, 0,     1'b0},
        '{CMD_DICT, "E",            "~",  3,     1'b1, 1'b0, 0,     1'b0},
        '{CMD_TEXT, "  A  B   C  ", "",   0,     1'b1, 1'b1, 2,     1'b0},
        '{CMD_TEXT, "C",            "x",  62,    1'b1, 1'b1, 1,     1'b0},
        '{CMD_TEXT, "C",            "x",  63,    1'b1, 1'b1, 0,     1'b0},
        '{CMD_DICT, "D",            "x",  63,    1'b1, 1'b0, 0,     1'b0},
        '{CMD_TEXT, "E~~~",         "",   0,     1'b1, 1'b1, 1,     1'b1},
        '{CMD_TEXT, "E~~~@A B",     "",   0,     1'b1, 1'b1, 1,     1'b1},
        '{CMD_DICT, "0",            "",   0,     1'b1, 1'b0, 0,     1'b0},
        '{CMD_TEXT, "0 A",          "",   0,     1'b1, 1'b0, 0,     1'b0},
        '{CMD_DICT, "F",            "y",  100,   1'b1, 1'b0, 0,     1'b0},
        '{CMD_TEXT, "A E~~~ ",      "",   0,     1'b0, 1'b0, 0,     1'b0},
        '{CMD_DICT, "G",            "",   0,     1'b1, 1'b0, 0,     1'b0},
        '{CMD_TEXT, "G",            "",   0,     1'b1, 1'b0, 0,     1'b0},
        '{CMD_TEXT, "A",            "",   0,     1'b1, 1'b0, 0,     1'b0}
    };

    dictionary_word_hit_counter i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_char_code     (i_char_code),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .o_hit_count     (o_hit_count),
        .o_dict_overflow (o_dict_overflow)
    );

    always #4 i_clk = ~i_clk;

    // unsigned byte compare of the token with one dictionary slot
    function automatic int compare_with_slot(int slot);
        int a;
        int b;
        int base;
        base = slot * WORD_BYTES;
        for (int i = 0; i < WORD_BYTES; i++) begin
            a = (i < tok_len) ? int'(tok_bytes[i]) : 0;
            b = dict_bytes.exists(base + i) ? int'(dict_bytes[base + i]) : 0;
            if (a != b) return (a < b) ? -1 : 1;
            if (a == 0) return 0;
        end
        return 0;
    endfunction

    // binary search over the committed words only
    function automatic bit token_in_dict();
        int lo;
        int hi;
        int mid;
        int order;
        lo = 0;
        hi = word_total - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            order = compare_with_slot(mid);
            if (order == 0) return 1'b1;
            if (order < 0) hi = mid - 1;
            else lo = mid + 1;
        end
        return 1'b0;
    endfunction

    function automatic void close_token();
        if (tok_len > 0 && !tok_over && token_in_dict() && hit_total != '1) hit_total++;
        tok_len = 0;
        tok_over = 1'b0;
    endfunction

    // advance the model by one item; returns 0 when the item is ignored
    function automatic bit score_item(logic cmd, logic [7:0] ch, logic last);
        bit used;
        used = 1'b1;
        if (cmd == CMD_DICT) begin
            if (load_len < WORD_BYTES - 1) begin
                if (word_total < WORD_SLOTS) dict_bytes[word_total * WORD_BYTES + load_len] = ch;
                load_len++;
            end else begin
                load_len = WORD_BYTES;
            end
            if (last) begin
                if (load_len <= WORD_BYTES - 1 && word_total < WORD_SLOTS) begin
                    dict_bytes[word_total * WORD_BYTES + load_len] = NUL_CHAR;
                    word_total++;
                end else begin
                    ovf_seen = 1'b1;
                end
                load_len = 0;
            end
            return used;
        end
        if (text_done) begin
            used = last;
        end else if (ch == NUL_CHAR) begin
            close_token();
            text_done = 1'b1;
        end else if (ch == SEPARATOR) begin
            close_token();
        end else if (tok_len < WORD_BYTES - 1) begin
            tok_bytes[tok_len] = ch;
            tok_len++;
        end else begin
            tok_over = 1'b1;
        end
        if (last) begin
            close_token();
            expected_tallies.push_back('{hit_count: hit_total, dict_overflow: ovf_seen});
            hit_total = '0;
            text_done = 1'b0;
        end
        return used;
    endfunction

    // compare one result with the oldest expected tally
    task automatic check_tally();
        t_tally want;
        if (expected_tallies.size() == 0) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: expected no result, got hit_count %0d dict_overflow %0d",
                         $time, o_hit_count, o_dict_overflow);
            fail_count++;
            return;
        end
        want = expected_tallies.pop_front();
        if (o_hit_count !== want.hit_count) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: hit_count expected %0d got %0d",
                         $time, want.hit_count, o_hit_count);
            fail_count++;
        end
        if (o_dict_overflow !== want.dict_overflow) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: dict_overflow expected %0d got %0d",
                         $time, want.dict_overflow, o_dict_overflow);
            fail_count++;
        end
    endtask

    // monitor: results first, then the item accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) check_tally();
            if (start && !busy) begin
                if (score_item(i_cmd, i_char_code, i_last)) used_items++;
            end
        end
    end

    // watchdog on cycles with nothing accepted and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // drive one item from a falling edge, with random idle cycles in front
    task automatic send_item(input logic cmd, input logic [7:0] ch, input logic last);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_char_code <= ch;
        i_last      <= last;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input logic cmd, input t_bytes bytes, input logic fin);
        foreach (bytes[i]) send_item(cmd, bytes[i], fin && (i == bytes.size() - 1));
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (expected_tallies.size() != 0);
    endtask

    function automatic logic [7:0] row_byte(logic [7:0] c);
        if (c == ZERO_MARK) return NUL_CHAR;
        if (c == HIGH_MARK) return 8'hFF;
        return c;
    endfunction

    // three-byte words above every earlier prefix, in increasing order
    task automatic load_fill_word();
        t_bytes w;
        w.push_back(8'h80 + 8'((fill_code >> 12) & 63));
        w.push_back(8'h80 + 8'((fill_code >> 6) & 63));
        w.push_back(8'h80 + 8'(fill_code & 63));
        fill_code++;
        send_bytes(CMD_DICT, w, 1'b1);
    endtask

    // message of known words, near misses, random and overlong tokens
    task automatic send_random_message();
        t_bytes msg;
        int     n_tok;
        int     pick;
        int     pos;
        int     len;
        n_tok = $urandom_range(1, 5);
        if ($urandom_range(3) == 0) msg.push_back(SEPARATOR);
        for (int t = 0; t < n_tok; t++) begin
            if (t != 0) repeat ($urandom_range(1, 3)) msg.push_back(SEPARATOR);
            pick = $urandom_range(9);
            if (pick < 7 && word_total != 0) begin
                pos = int'($urandom_range(word_total - 1)) * WORD_BYTES;
                len = 0;
                while (len < WORD_BYTES && dict_bytes.exists(pos + len)
                       && dict_bytes[pos + len] != NUL_CHAR) begin
                    msg.push_back(dict_bytes[pos + len]);
                    len++;
                end
                if (pick == 6) begin
                    if ($urandom_range(1) != 0) msg.push_back(8'($urandom_range(1, 255)));
                    else if (len > 1) void'(msg.pop_back());
                end
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(60, 70)) msg.push_back(8'($urandom_range(97, 122)));
            end
        end
        if ($urandom_range(3) == 0) msg.push_back(SEPARATOR);
        // early end of text with junk behind it
        if ($urandom_range(11) == 0) begin
            msg.insert($urandom_range(msg.size()), NUL_CHAR);
            repeat ($urandom_range(0, 4)) msg.push_back(8'($urandom_range(255)));
        end
        if (msg.size() == 0) msg.push_back(SEPARATOR);
        send_bytes(CMD_TEXT, msg, 1'b1);
    endtask

    initial begin
        t_bytes word;
        int     items_base;
        int     pick;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = CMD_DICT;
        i_char_code = '0;
        i_last      = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        idle_pct = 31;
        foreach (dir_rows[r]) begin
            word.delete();
            for (int i = 0; i < dir_rows[r].head.len(); i++)
                word.push_back(row_byte(dir_rows[r].head[i]));
            repeat (dir_rows[r].reps) begin
                for (int i = 0; i < dir_rows[r].rep.len(); i++)
                    word.push_back(row_byte(dir_rows[r].rep[i]));
            end
            send_bytes(dir_rows[r].cmd, word, dir_rows[r].fin);
            if (dir_rows[r].chk)
                expected_tallies[expected_tallies.size() - 1] =
                    '{hit_count: HIT_W'(dir_rows[r].hits), dict_overflow: dir_rows[r].ovf};
        end
        pause_until_drained();

        // random traffic in three idling segments, draining between them
        items_base = used_items;
        for (int seg = 0; seg < 3; seg++) begin
            idle_pct = (seg == 0) ? 31 : (seg == 1) ? 81 : 0;
            while (used_items - items_base < (seg + 1) * RANDOM_ITEMS / 3) begin
                pick = $urandom_range(99);
                if (pick < 25) begin
                    // sorted words: five-letter prefix from a rising code, short or overlong tail
                    repeat ($urandom_range(1, 4)) begin
                        word.delete();
                        word_code += $urandom_range(1, 6);
                        for (int d = 4; d >= 0; d--)
                            word.push_back(8'h61 + 8'((word_code >> (4 * d)) & 15));
                        repeat (($urandom_range(9) == 0) ? $urandom_range(58, 66)
                                                         : $urandom_range(0, 3))
                            word.push_back(8'($urandom_range(1, 255)));
                        send_bytes(CMD_DICT, word, 1'b1);
                    end
                end else if (pick < 85) begin
                    send_random_message();
                end else begin
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                              $urandom_range(3) == 0);
                end
            end
            pause_until_drained();
        end

        // fill every slot, then words that no longer fit, then search the full dictionary
        while (word_total < WORD_SLOTS) load_fill_word();
        repeat (2) load_fill_word();
        repeat (30) send_random_message();
        pause_until_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (expected_tallies.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== dictionary_word_hit_counter.f =====
src/dwhc_pkg.sv
src/dwhc_front.sv
src/dwhc_queue.sv
src/dwhc_back.sv
src/dictionary_word_hit_counter.sv
test/tb_top.sv
